// File: sv/utf8_line_editor_with_history_top_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 line editor assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_LINE_EDITOR_WITH_HISTORY_TOP_MACROS_SVH
`define UTF8_LINE_EDITOR_WITH_HISTORY_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold in every cycle out of reset
`define ULE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define ULE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ULE_ASSERT(lbl, prop, msg)
`define ULE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/ule_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 line editor package
// Sizes, key codes, sequencer types and UTF-8 helper functions.
// ----------------------------------------------------------------------------
package ule_pkg;

    // sizes
    localparam int LINE_MAX   = 256;
    localparam int LINE_AW    = $clog2(LINE_MAX);
    localparam int LEN_W      = LINE_AW + 1;
    localparam int HIST_DEPTH = 16;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int CNT_W      = HIST_AW + 1;
    localparam int HADDR_W    = HIST_AW + LINE_AW;

    // transaction op codes
    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_ACCEPT = 2'd2;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTER = 2'd1;
    localparam logic [1:0] EV_EOF   = 2'd2;

    // key bytes
    localparam logic [7:0] KEY_CTRL_A = 8'h01;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_CTRL_E = 8'h05;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_CTRL_K = 8'h0b;
    localparam logic [7:0] KEY_CR     = 8'h0d;
    localparam logic [7:0] KEY_CTRL_U = 8'h15;
    localparam logic [7:0] KEY_CTRL_W = 8'h17;
    localparam logic [7:0] KEY_ESC    = 8'h1b;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_DEL    = 8'h7f;

    // escape sequence bytes
    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_O       = 8'h4f;
    localparam logic [7:0] CH_UP      = 8'h41;
    localparam logic [7:0] CH_DOWN    = 8'h42;
    localparam logic [7:0] CH_RIGHT   = 8'h43;
    localparam logic [7:0] CH_LEFT    = 8'h44;
    localparam logic [7:0] CH_HOME    = 8'h48;
    localparam logic [7:0] CH_END     = 8'h46;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] PARAM_1    = 8'h31;
    localparam logic [7:0] PARAM_3    = 8'h33;
    localparam logic [7:0] PARAM_4    = 8'h34;
    localparam logic [7:0] PARAM_7    = 8'h37;
    localparam logic [7:0] PARAM_8    = 8'h38;

    // escape phases
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_SEEN  = 2'd1;
    localparam logic [1:0] ESC_PARAM = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_READ    = 7'b0000010,
        S_CLEN    = 7'b0000100,
        S_SCAN_RD = 7'b0001000,
        S_SCAN_CK = 7'b0010000,
        S_COPY    = 7'b0100000,
        S_CMP     = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        SK_BACK,
        SK_WSP,
        SK_WRD,
        SK_WCONT
    } scan_kind_t;

    typedef enum logic [2:0] {
        CK_LINE_LINE,
        CK_LINE_SAVED,
        CK_SAVED_LINE,
        CK_HIST_LINE,
        CK_LINE_HIST
    } cp_kind_t;

    typedef enum logic [1:0] {
        CT_FIN,
        CT_INSERT,
        CT_LOAD
    } cp_then_t;

    // UTF-8 continuation byte
    function automatic logic is_cont(input logic [7:0] b);
        return b inside {[8'h80:8'hbf]};
    endfunction

    // character length given by a lead byte; invalid leads count as one
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd1;
        if (b inside {[8'hc2:8'hdf]}) n = 3'd2;
        else if (b inside {[8'he0:8'hef]}) n = 3'd3;
        else if (b inside {[8'hf0:8'hf4]}) n = 3'd4;
        return n;
    endfunction

endpackage

// File: sv/ule_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ule_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/utf8_line_editor_with_history_top.sv
// ----------------------------------------------------------------------------
// UTF-8 line editor with history
// Edits one line from keyboard bytes and keeps a circular history of lines.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low; op selects a
//   key byte, a read of one line byte at read_index, or accepting the line.
//   Exactly one result follows per transaction: done is high for one cycle
//   with event_res, bell, line_length, cursor, read_byte and history_count.
//   The receiver cannot stall; results must be taken in the strobe cycle.
// Sequencing:
//   Simple keys and unknown ops finish straight from idle. Reads and cursor
//   moves right read the line RAM first. Left, backspace and Ctrl-W scan the
//   line backward, a read and then a check per byte scanned. Insert, delete,
//   history load and save run a byte copy through the line, saved and history
//   RAMs at one byte per cycle; accept compares with the newest entry, then
//   copies. Throughput is one transaction at a time: busy holds off start
//   until the sequencer is back in idle.
// Reset:
//   rst_n clears the line, cursor, history count and escape state at once;
//   RAM contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
`include "utf8_line_editor_with_history_top_macros.svh"

module utf8_line_editor_with_history_top
    import ule_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [7:0]        key_byte,
    input  logic [7:0]        read_index,
    output logic              done,
    output logic [1:0]        event_res,
    output logic              bell,
    output logic [LEN_W-1:0]  line_length,
    output logic [LEN_W-1:0]  cursor,
    output logic [7:0]        read_byte,
    output logic [CNT_W-1:0]  history_count
);

    // control state
    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   line_len_reg, line_len_next;
    logic [LEN_W-1:0]   cursor_reg, cursor_next;
    logic [LEN_W-1:0]   saved_len_reg, saved_len_next;
    logic [CNT_W-1:0]   hist_used_reg, hist_used_next;
    logic [HIST_AW-1:0] hist_oldest_reg, hist_oldest_next;
    logic               browsing_reg, browsing_next;
    logic [HIST_AW-1:0] bidx_reg, bidx_next;
    logic [1:0]         esc_reg, esc_next;
    logic [7:0]         first_param_reg, first_param_next;
    logic [2:0]         param_cnt_reg, param_cnt_next;
    logic [7:0]         key_reg, key_next;

    // scan and copy sequencer
    logic [LEN_W-1:0]   scan_p_reg, scan_p_next;
    scan_kind_t         scan_kind_reg, scan_kind_next;
    logic               scan_cut_reg, scan_cut_next;
    logic               clen_del_reg, clen_del_next;
    cp_kind_t           cp_kind_reg, cp_kind_next;
    cp_then_t           cp_then_reg, cp_then_next;
    logic [LINE_AW-1:0] cp_src_reg, cp_src_next;
    logic [LINE_AW-1:0] cp_dst_reg, cp_dst_next;
    logic [LEN_W-1:0]   cp_left_reg, cp_left_next;
    logic               cp_down_reg, cp_down_next;
    logic [HIST_AW-1:0] cp_slot_reg, cp_slot_next;
    logic               cp_pend_reg, cp_pend_next;
    logic [LINE_AW-1:0] cp_pdst_reg, cp_pdst_next;
    logic               cmp_miss_reg, cmp_miss_next;

    // result registers
    logic               done_reg, done_next;
    logic [1:0]         ev_reg, ev_next;
    logic               bell_reg, bell_next;
    logic [7:0]         rd_reg, rd_next;

    // history line lengths
    logic [LEN_W-1:0]   hist_len_reg [HIST_DEPTH];
    logic               hl_we;
    logic [HIST_AW-1:0] hl_widx;
    logic [HIST_AW-1:0] hl_ridx;
    logic [LEN_W-1:0]   hl_rdata;

    // RAM ports
    logic               line_we, saved_we, hist_we;
    logic [LINE_AW-1:0] line_waddr, line_raddr, saved_waddr, saved_raddr;
    logic [HADDR_W-1:0] hist_waddr, hist_raddr;
    logic [7:0]         line_wdata, saved_wdata, hist_wdata;
    logic [7:0]         line_rdata, saved_rdata, hist_rdata;
    logic [7:0]         cp_rdata;

    // helpers
    logic [HIST_AW-1:0] newest_slot, load_slot;
    logic               fin, fin_bell;
    logic [1:0]         fin_ev;
    logic [7:0]         fin_rd;
    logic               cut_go, load_go, store_go, clear_go;
    logic [LEN_W-1:0]   cut_from, cut_to;
    logic [7:0]         p0;
    logic [2:0]         clen_n;

    assign newest_slot = hist_oldest_reg + HIST_AW'(hist_used_reg - 1'b1);
    assign load_slot   = hist_oldest_reg + bidx_reg;
    assign hl_ridx     = (state_reg == S_IDLE) ? newest_slot : load_slot;
    assign hl_rdata    = hist_len_reg[hl_ridx];
    assign p0          = (param_cnt_reg != 3'd0) ? first_param_reg : 8'h00;

    // source byte of the copy in flight
    always_comb
    begin
        case (cp_kind_reg)
            CK_SAVED_LINE: cp_rdata = saved_rdata;
            CK_HIST_LINE:  cp_rdata = hist_rdata;
            default:       cp_rdata = line_rdata;
        endcase
    end

    // character length at the cursor; one if it would run past the line end
    always_comb
    begin
        clen_n = lead_len(line_rdata);
        if ((cursor_reg + LEN_W'(clen_n)) > line_len_reg)
        begin
            clen_n = 3'd1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        line_len_next    = line_len_reg;
        cursor_next      = cursor_reg;
        saved_len_next   = saved_len_reg;
        hist_used_next   = hist_used_reg;
        hist_oldest_next = hist_oldest_reg;
        browsing_next    = browsing_reg;
        bidx_next        = bidx_reg;
        esc_next         = esc_reg;
        first_param_next = first_param_reg;
        param_cnt_next   = param_cnt_reg;
        key_next         = key_reg;
        scan_p_next      = scan_p_reg;
        scan_kind_next   = scan_kind_reg;
        scan_cut_next    = scan_cut_reg;
        clen_del_next    = clen_del_reg;
        cp_kind_next     = cp_kind_reg;
        cp_then_next     = cp_then_reg;
        cp_src_next      = cp_src_reg;
        cp_dst_next      = cp_dst_reg;
        cp_left_next     = cp_left_reg;
        cp_down_next     = cp_down_reg;
        cp_slot_next     = cp_slot_reg;
        cp_pend_next     = cp_pend_reg;
        cp_pdst_next     = cp_pdst_reg;
        cmp_miss_next    = cmp_miss_reg;
        done_next        = 1'b0;
        ev_next          = ev_reg;
        bell_next        = bell_reg;
        rd_next          = rd_reg;

        fin      = 1'b0;
        fin_ev   = EV_NONE;
        fin_bell = 1'b0;
        fin_rd   = 8'h00;
        cut_go   = 1'b0;
        cut_from = cursor_reg;
        cut_to   = cursor_reg;
        load_go  = 1'b0;
        store_go = 1'b0;
        clear_go = 1'b0;

        line_we     = 1'b0;
        line_waddr  = cp_pdst_reg;
        line_wdata  = cp_rdata;
        line_raddr  = cp_src_reg;
        saved_we    = 1'b0;
        saved_waddr = cp_pdst_reg;
        saved_wdata = cp_rdata;
        saved_raddr = cp_src_reg;
        hist_we     = 1'b0;
        hist_waddr  = {cp_slot_reg, cp_pdst_reg};
        hist_wdata  = cp_rdata;
        hist_raddr  = {cp_slot_reg, cp_src_reg};
        hl_we       = 1'b0;
        hl_widx     = hist_oldest_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next = key_byte;
                    if (op == OP_KEY)
                    begin
                        if (esc_reg == ESC_SEEN)
                        begin
                            param_cnt_next   = 3'd0;
                            first_param_next = 8'h00;
                            esc_next = (key_byte == CH_BRACKET || key_byte == CH_O) ?
                                       ESC_PARAM : ESC_NONE;
                            fin = 1'b1;
                        end
                        else if (esc_reg != ESC_NONE && key_byte inside {[8'h30:8'h3f]})
                        begin
                            if (param_cnt_reg < 3'd4)
                            begin
                                if (param_cnt_reg == 3'd0)
                                begin
                                    first_param_next = key_byte;
                                end
                                param_cnt_next = param_cnt_reg + 3'd1;
                            end
                            fin = 1'b1;
                        end
                        else if (esc_reg != ESC_NONE)
                        begin
                            // final byte of an escape sequence
                            esc_next = ESC_NONE;
                            fin      = 1'b1;
                            case (key_byte)
                                CH_UP:
                                begin
                                    if (hist_used_reg == '0)
                                    begin
                                        fin_bell = 1'b1;
                                    end
                                    else if (!browsing_reg)
                                    begin
                                        fin            = 1'b0;
                                        saved_len_next = line_len_reg;
                                        browsing_next  = 1'b1;
                                        bidx_next      = HIST_AW'(hist_used_reg - 1'b1);
                                        cp_kind_next   = CK_LINE_SAVED;
                                        cp_then_next   = CT_LOAD;
                                        cp_src_next    = '0;
                                        cp_dst_next    = '0;
                                        cp_down_next   = 1'b0;
                                        cp_left_next   = line_len_reg;
                                        cp_pend_next   = 1'b0;
                                        state_next     = S_COPY;
                                    end
                                    else if (bidx_reg == '0)
                                    begin
                                        fin_bell = 1'b1;
                                    end
                                    else
                                    begin
                                        fin          = 1'b0;
                                        bidx_next    = bidx_reg - 1'b1;
                                        cp_then_next = CT_LOAD;
                                        cp_left_next = '0;
                                        cp_pend_next = 1'b0;
                                        state_next   = S_COPY;
                                    end
                                end
                                CH_DOWN:
                                begin
                                    if (browsing_reg)
                                    begin
                                        fin          = 1'b0;
                                        cp_pend_next = 1'b0;
                                        state_next   = S_COPY;
                                        if (({1'b0, bidx_reg} + CNT_W'(1)) >= hist_used_reg)
                                        begin
                                            browsing_next = 1'b0;
                                            bidx_next     = '0;
                                            line_len_next = saved_len_reg;
                                            cursor_next   = saved_len_reg;
                                            cp_kind_next  = CK_SAVED_LINE;
                                            cp_then_next  = CT_FIN;
                                            cp_src_next   = '0;
                                            cp_dst_next   = '0;
                                            cp_down_next  = 1'b0;
                                            cp_left_next  = saved_len_reg;
                                        end
                                        else
                                        begin
                                            bidx_next    = bidx_reg + 1'b1;
                                            cp_then_next = CT_LOAD;
                                            cp_left_next = '0;
                                        end
                                    end
                                end
                                CH_RIGHT:
                                begin
                                    if (cursor_reg >= line_len_reg)
                                    begin
                                        fin_bell = 1'b1;
                                    end
                                    else
                                    begin
                                        fin           = 1'b0;
                                        line_raddr    = cursor_reg[LINE_AW-1:0];
                                        clen_del_next = 1'b0;
                                        state_next    = S_CLEN;
                                    end
                                end
                                CH_LEFT:
                                begin
                                    if (cursor_reg == '0)
                                    begin
                                        fin_bell = 1'b1;
                                    end
                                    else
                                    begin
                                        fin            = 1'b0;
                                        scan_p_next    = cursor_reg - 1'b1;
                                        scan_kind_next = SK_BACK;
                                        scan_cut_next  = 1'b0;
                                        state_next     = S_SCAN_RD;
                                    end
                                end
                                CH_HOME: cursor_next = '0;
                                CH_END:  cursor_next = line_len_reg;
                                CH_TILDE:
                                begin
                                    if (p0 == PARAM_1 || p0 == PARAM_7)
                                    begin
                                        cursor_next = '0;
                                    end
                                    else if (p0 == PARAM_4 || p0 == PARAM_8)
                                    begin
                                        cursor_next = line_len_reg;
                                    end
                                    else if (p0 == PARAM_3)
                                    begin
                                        if (cursor_reg >= line_len_reg)
                                        begin
                                            fin_bell = 1'b1;
                                        end
                                        else
                                        begin
                                            fin           = 1'b0;
                                            line_raddr    = cursor_reg[LINE_AW-1:0];
                                            clen_del_next = 1'b1;
                                            state_next    = S_CLEN;
                                        end
                                    end
                                end
                                default: fin = 1'b1;
                            endcase
                        end
                        else
                        begin
                            fin = 1'b1;
                            case (key_byte)
                                KEY_ESC: esc_next = ESC_SEEN;
                                KEY_CR:  fin_ev = EV_ENTER;
                                KEY_BS, KEY_DEL:
                                begin
                                    if (cursor_reg == '0)
                                    begin
                                        fin_bell = 1'b1;
                                    end
                                    else
                                    begin
                                        fin            = 1'b0;
                                        scan_p_next    = cursor_reg - 1'b1;
                                        scan_kind_next = SK_BACK;
                                        scan_cut_next  = 1'b1;
                                        state_next     = S_SCAN_RD;
                                    end
                                end
                                KEY_CTRL_A: cursor_next = '0;
                                KEY_CTRL_E: cursor_next = line_len_reg;
                                KEY_CTRL_K:
                                begin
                                    if (cursor_reg < line_len_reg)
                                    begin
                                        line_len_next = cursor_reg;
                                    end
                                end
                                KEY_CTRL_U:
                                begin
                                    line_len_next = '0;
                                    cursor_next   = '0;
                                end
                                KEY_CTRL_W:
                                begin
                                    fin            = 1'b0;
                                    scan_p_next    = cursor_reg;
                                    scan_kind_next = SK_WSP;
                                    scan_cut_next  = 1'b1;
                                    state_next     = S_SCAN_RD;
                                end
                                KEY_CTRL_D:
                                begin
                                    if (line_len_reg == '0)
                                    begin
                                        fin_ev = EV_EOF;
                                    end
                                end
                                default:
                                begin
                                    if (key_byte < KEY_SPACE)
                                    begin
                                        fin = 1'b1;
                                    end
                                    else if (line_len_reg >= LEN_W'(LINE_MAX))
                                    begin
                                        fin_bell = 1'b1;
                                    end
                                    else
                                    begin
                                        // open a gap at the cursor, top byte first
                                        fin          = 1'b0;
                                        cp_kind_next = CK_LINE_LINE;
                                        cp_then_next = CT_INSERT;
                                        cp_src_next  = LINE_AW'(line_len_reg - 1'b1);
                                        cp_dst_next  = line_len_reg[LINE_AW-1:0];
                                        cp_down_next = 1'b1;
                                        cp_left_next = line_len_reg - cursor_reg;
                                        cp_pend_next = 1'b0;
                                        state_next   = S_COPY;
                                    end
                                end
                            endcase
                        end
                    end
                    else if (op == OP_READ)
                    begin
                        if ({1'b0, read_index} < line_len_reg)
                        begin
                            line_raddr = read_index;
                            state_next = S_READ;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    else if (op == OP_ACCEPT)
                    begin
                        if (line_len_reg == '0)
                        begin
                            clear_go = 1'b1;
                            fin      = 1'b1;
                        end
                        else
                        begin
                            // compare with the newest entry; no candidate means a miss
                            cp_slot_next = newest_slot;
                            cp_src_next  = '0;
                            cp_pend_next = 1'b0;
                            state_next   = S_CMP;
                            if (hist_used_reg != '0 && hl_rdata == line_len_reg)
                            begin
                                cp_left_next  = line_len_reg;
                                cmp_miss_next = 1'b0;
                            end
                            else
                            begin
                                cp_left_next  = '0;
                                cmp_miss_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end

            S_READ:
            begin
                fin    = 1'b1;
                fin_rd = line_rdata;
            end

            S_CLEN:
            begin
                if (!clen_del_reg)
                begin
                    cursor_next = cursor_reg + LEN_W'(clen_n);
                    fin         = 1'b1;
                end
                else
                begin
                    cut_go   = 1'b1;
                    cut_from = cursor_reg;
                    cut_to   = cursor_reg + LEN_W'(clen_n);
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CK;
                case (scan_kind_reg)
                    SK_BACK:
                    begin
                        line_raddr = scan_p_reg[LINE_AW-1:0];
                        if (scan_p_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    SK_WCONT:
                    begin
                        line_raddr = scan_p_reg[LINE_AW-1:0];
                        if (scan_p_reg == '0 || scan_p_reg >= cursor_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        line_raddr = LINE_AW'(scan_p_reg - 1'b1);
                        if (scan_p_reg == '0)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_SCAN_CK:
            begin
                state_next = S_SCAN_RD;
                case (scan_kind_reg)
                    SK_WSP:
                    begin
                        if (line_rdata == KEY_SPACE)
                        begin
                            scan_p_next = scan_p_reg - 1'b1;
                        end
                        else
                        begin
                            scan_kind_next = SK_WRD;
                        end
                    end
                    SK_WRD:
                    begin
                        if (line_rdata != KEY_SPACE)
                        begin
                            scan_p_next = scan_p_reg - 1'b1;
                        end
                        else
                        begin
                            scan_kind_next = SK_WCONT;
                        end
                    end
                    default:
                    begin
                        if (is_cont(line_rdata))
                        begin
                            scan_p_next = scan_p_reg - 1'b1;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_COPY:
            begin
                // write back the byte read last cycle
                if (cp_pend_reg)
                begin
                    case (cp_kind_reg)
                        CK_LINE_SAVED: saved_we = 1'b1;
                        CK_LINE_HIST:  hist_we  = 1'b1;
                        default:       line_we  = 1'b1;
                    endcase
                end
                // issue the next read
                if (cp_left_reg != '0)
                begin
                    cp_pend_next = 1'b1;
                    cp_pdst_next = cp_dst_reg;
                    cp_src_next  = cp_down_reg ? cp_src_reg - 1'b1 : cp_src_reg + 1'b1;
                    cp_dst_next  = cp_down_reg ? cp_dst_reg - 1'b1 : cp_dst_reg + 1'b1;
                    cp_left_next = cp_left_reg - 1'b1;
                end
                else
                begin
                    cp_pend_next = 1'b0;
                    if (!cp_pend_reg)
                    begin
                        case (cp_then_reg)
                            CT_INSERT:
                            begin
                                line_we       = 1'b1;
                                line_waddr    = cursor_reg[LINE_AW-1:0];
                                line_wdata    = key_reg;
                                cursor_next   = cursor_reg + 1'b1;
                                line_len_next = line_len_reg + 1'b1;
                                fin           = 1'b1;
                            end
                            CT_LOAD: load_go = 1'b1;
                            default: fin = 1'b1;
                        endcase
                    end
                end
            end

            S_CMP:
            begin
                if (cp_pend_reg && line_rdata != hist_rdata)
                begin
                    cmp_miss_next = 1'b1;
                end
                if (cp_left_reg != '0)
                begin
                    cp_pend_next = 1'b1;
                    cp_src_next  = cp_src_reg + 1'b1;
                    cp_left_next = cp_left_reg - 1'b1;
                end
                else
                begin
                    cp_pend_next = 1'b0;
                    if (!cp_pend_reg)
                    begin
                        if (cmp_miss_reg)
                        begin
                            store_go = 1'b1;
                        end
                        else
                        begin
                            clear_go = 1'b1;
                            fin      = 1'b1;
                        end
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase

        // end of a backward scan
        if ((state_reg == S_SCAN_RD || state_reg == S_SCAN_CK) && state_next == S_IDLE)
        begin
            if (!scan_cut_reg)
            begin
                cursor_next = scan_p_reg;
                fin         = 1'b1;
            end
            else if (scan_p_reg == cursor_reg)
            begin
                fin_bell = 1'b1;
                fin      = 1'b1;
            end
            else
            begin
                cut_go   = 1'b1;
                cut_from = scan_p_reg;
                cut_to   = cursor_reg;
            end
        end

        // remove bytes from cut_from up to cut_to, tail moved down
        if (cut_go)
        begin
            line_len_next = line_len_reg - (cut_to - cut_from);
            cursor_next   = cut_from;
            cp_kind_next  = CK_LINE_LINE;
            cp_then_next  = CT_FIN;
            cp_src_next   = cut_to[LINE_AW-1:0];
            cp_dst_next   = cut_from[LINE_AW-1:0];
            cp_down_next  = 1'b0;
            cp_left_next  = line_len_reg - cut_to;
            cp_pend_next  = 1'b0;
            state_next    = S_COPY;
        end

        // copy the selected history entry into the line
        if (load_go)
        begin
            line_len_next = hl_rdata;
            cursor_next   = hl_rdata;
            cp_kind_next  = CK_HIST_LINE;
            cp_then_next  = CT_FIN;
            cp_slot_next  = load_slot;
            cp_src_next   = '0;
            cp_dst_next   = '0;
            cp_down_next  = 1'b0;
            cp_left_next  = hl_rdata;
            cp_pend_next  = 1'b0;
            state_next    = S_COPY;
        end

        // save the line as a new history entry
        if (store_go)
        begin
            if (hist_used_reg < CNT_W'(HIST_DEPTH))
            begin
                hl_widx        = hist_oldest_reg + hist_used_reg[HIST_AW-1:0];
                hist_used_next = hist_used_reg + 1'b1;
            end
            else
            begin
                hl_widx          = hist_oldest_reg;
                hist_oldest_next = hist_oldest_reg + 1'b1;
            end
            hl_we        = 1'b1;
            cp_kind_next = CK_LINE_HIST;
            cp_then_next = CT_FIN;
            cp_slot_next = hl_widx;
            cp_src_next  = '0;
            cp_dst_next  = '0;
            cp_down_next = 1'b0;
            cp_left_next = line_len_reg;
            cp_pend_next = 1'b0;
            clear_go     = 1'b1;
            state_next   = S_COPY;
        end

        // accept: empty line, back to editing
        if (clear_go)
        begin
            line_len_next = '0;
            cursor_next   = '0;
            browsing_next = 1'b0;
            bidx_next     = '0;
        end

        // close the transaction
        if (fin)
        begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            ev_next    = fin_ev;
            bell_next  = fin_bell;
            rd_next    = fin_rd;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            line_len_reg    <= '0;
            cursor_reg      <= '0;
            saved_len_reg   <= '0;
            hist_used_reg   <= '0;
            hist_oldest_reg <= '0;
            browsing_reg    <= 1'b0;
            bidx_reg        <= '0;
            esc_reg         <= ESC_NONE;
            first_param_reg <= '0;
            param_cnt_reg   <= '0;
            key_reg         <= '0;
            scan_p_reg      <= '0;
            scan_kind_reg   <= SK_BACK;
            scan_cut_reg    <= 1'b0;
            clen_del_reg    <= 1'b0;
            cp_kind_reg     <= CK_LINE_LINE;
            cp_then_reg     <= CT_FIN;
            cp_src_reg      <= '0;
            cp_dst_reg      <= '0;
            cp_left_reg     <= '0;
            cp_down_reg     <= 1'b0;
            cp_slot_reg     <= '0;
            cp_pend_reg     <= 1'b0;
            cp_pdst_reg     <= '0;
            cmp_miss_reg    <= 1'b0;
            done_reg        <= 1'b0;
            ev_reg          <= EV_NONE;
            bell_reg        <= 1'b0;
            rd_reg          <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            line_len_reg    <= line_len_next;
            cursor_reg      <= cursor_next;
            saved_len_reg   <= saved_len_next;
            hist_used_reg   <= hist_used_next;
            hist_oldest_reg <= hist_oldest_next;
            browsing_reg    <= browsing_next;
            bidx_reg        <= bidx_next;
            esc_reg         <= esc_next;
            first_param_reg <= first_param_next;
            param_cnt_reg   <= param_cnt_next;
            key_reg         <= key_next;
            scan_p_reg      <= scan_p_next;
            scan_kind_reg   <= scan_kind_next;
            scan_cut_reg    <= scan_cut_next;
            clen_del_reg    <= clen_del_next;
            cp_kind_reg     <= cp_kind_next;
            cp_then_reg     <= cp_then_next;
            cp_src_reg      <= cp_src_next;
            cp_dst_reg      <= cp_dst_next;
            cp_left_reg     <= cp_left_next;
            cp_down_reg     <= cp_down_next;
            cp_slot_reg     <= cp_slot_next;
            cp_pend_reg     <= cp_pend_next;
            cp_pdst_reg     <= cp_pdst_next;
            cmp_miss_reg    <= cmp_miss_next;
            done_reg        <= done_next;
            ev_reg          <= ev_next;
            bell_reg        <= bell_next;
            rd_reg          <= rd_next;
        end
    end

    // history lengths, written on store only
    always_ff @(posedge clk)
    begin
        if (hl_we)
        begin
            hist_len_reg[hl_widx] <= line_len_reg;
        end
    end

    // line, saved line and history byte stores
    ule_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    ule_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_saved_ram (
        .clk   (clk),
        .we    (saved_we),
        .waddr (saved_waddr),
        .wdata (saved_wdata),
        .raddr (saved_raddr),
        .rdata (saved_rdata)
    );

    ule_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH * LINE_MAX)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // ports
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign event_res     = ev_reg;
    assign bell          = bell_reg;
    assign line_length   = line_len_reg;
    assign cursor        = cursor_reg;
    assign read_byte     = rd_reg;
    assign history_count = hist_used_reg;

    // checks
    `ULE_ASSERT(a_done_when_idle, done |-> !busy, "result strobe while sequencer busy")
    `ULE_ASSERT(a_cursor_in_line, cursor_reg <= line_len_reg, "cursor beyond line end")
    `ULE_ASSERT(a_hist_bound, hist_used_reg <= CNT_W'(HIST_DEPTH), "history count overflow")
    `ULE_ASSERT_NEXT(a_start_result, start && !busy && op == OP_READ && read_index == 8'h00 && line_len_reg == '0, done, "empty line read must finish in one cycle")

endmodule
